@@ rtl/rwhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_pkg: shared types and constants of the RIFF/WAVE header parser
// Phase and result codes, chunk name words, the item and result records
// passed between the parser stages, and the ASCII upper-case helper.
// ----------------------------------------------------------------------------
package rwhp_pkg;

	// Default width of the saturating stream position counter.
	localparam int unsigned POSITION_BITS_DEF = 40;
	// Largest fmt chunk that is captured; larger ones are skipped.
	localparam int unsigned FMT_MAX_BYTES = 40;
	// Only fmt bytes 0..23 carry fields that are used.
	localparam int unsigned FMT_BUF_BYTES = 24;
	localparam int unsigned OFFSET_BITS = 40;

	// Chunk names as they sit in the name shift register (first byte lowest),
	// after case folding.
	localparam logic [31:0] NAME_RIFF = 32'h4646_4952;
	localparam logic [31:0] NAME_WAVE = 32'h4556_4157;
	localparam logic [31:0] NAME_FMT  = 32'h2054_4D46;
	localparam logic [31:0] NAME_DATA = 32'h4154_4144;

	localparam logic [15:0] TAG_PCM = 16'h0001;
	localparam logic [15:0] TAG_EXT = 16'hFFFE;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHUNK,
		PH_FMT,
		PH_SKIP,
		PH_FAILED
	} rwhp_phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_HEADER,
		ST_TRUNC_FMT,
		ST_NO_FORMAT
	} rwhp_status_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN,
		KIND_PCM,
		KIND_EXT
	} rwhp_kind_t;

	// Registered input item as seen by the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       eos;
	} rwhp_item_t;

	typedef struct packed {
		rwhp_status_t           status;
		rwhp_kind_t             format_kind;
		logic [15:0]            channel_count;
		logic [31:0]            sample_rate;
		logic [31:0]            byte_rate;
		logic [15:0]            block_align;
		logic [15:0]            sample_bits;
		logic [15:0]            valid_bits;
		logic [31:0]            speaker_mask;
		logic [OFFSET_BITS-1:0] data_offset;
		logic [31:0]            data_size;
	} rwhp_result_t;

	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
	endfunction

endpackage

@@ rtl/rwhp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_in_if: byte stream channel
// Valid/ready channel carrying one file byte and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface rwhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source(output valid, output data_byte, output end_of_stream, input ready);
	modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

@@ rtl/rwhp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_out_if: summary channel
// Valid/ready channel carrying the summary of one parsed file.
// ----------------------------------------------------------------------------
interface rwhp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  format_kind;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [31:0] byte_rate;
	logic [15:0] block_align;
	logic [15:0] sample_bits;
	logic [15:0] valid_bits;
	logic [31:0] speaker_mask;
	logic [39:0] data_offset;
	logic [31:0] data_size;

	modport source(output valid, output status, output format_kind, output channel_count,
		output sample_rate, output byte_rate, output block_align, output sample_bits,
		output valid_bits, output speaker_mask, output data_offset, output data_size,
		input ready);
	modport sink(input valid, input status, input format_kind, input channel_count,
		input sample_rate, input byte_rate, input block_align, input sample_bits,
		input valid_bits, input speaker_mask, input data_offset, input data_size,
		output ready);
endinterface

@@ rtl/riff_wave_header_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_wave_header_parser_top: RIFF/WAVE header parser
// Takes a WAV file one byte per item, checks the RIFF/WAVE header, walks the
// chunk headers, captures an fmt chunk of up to 40 bytes and the last data
// chunk, and gives one summary item on the final byte of each file.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake     Payload
//  stream    in   valid/ready   data_byte[7:0], end_of_stream
//  summary   out  valid/ready   status, format_kind, format fields,
//                               data_offset[39:0], data_size[31:0]
//
// One byte is taken every cycle while no final byte waits. A byte is
// registered on entry and parsed from the input register by a single pass of
// small compare and counter logic; the summary of a file is loaded into the
// summary register when its final byte is taken and is offered from there.
// A final byte is held in the input register while an earlier summary is
// still unclaimed, and the bytes behind it wait too; other bytes flow
// regardless of summary stalls. arst_n clears all parse state but the fmt
// buffer at once, with no clearing pass; bytes are accepted right after reset.
//
// The fmt chunk is captured into a 24-byte buffer, which holds every field
// the summary needs; bytes beyond that are counted but not kept. The stream
// position counter is POSITION_BITS wide and saturates.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_top #(
	parameter int unsigned POSITION_BITS = rwhp_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rwhp_in_if.sink     stream,
	rwhp_out_if.source  summary
);

	rwhp_pkg::rwhp_item_t   item;
	rwhp_pkg::rwhp_result_t res;
	logic                   take;
	logic                   res_valid;
	logic                   out_free;

	// Input register: holds each accepted byte for the parse logic.
	rwhp_in_stage u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.take   (take),
		.item   (item)
	);

	// Parse state and summary formation, one byte per cycle while no final byte waits.
	rwhp_parser #(
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.out_free  (out_free),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	// Summary register: holds a finished summary while parsing continues.
	rwhp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res      (res),
		.out_free (out_free),
		.summary  (summary)
	);

endmodule

@@ rtl/rwhp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_in_stage: input register
// Holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module rwhp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	rwhp_in_if.sink            stream,
	input  logic               take,
	output rwhp_pkg::rwhp_item_t item
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	assign stream.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
			eos_s1  <= stream.end_of_stream;
		end
	end

	assign item.valid     = valid_s1;
	assign item.data_byte = byte_s1;
	assign item.eos       = eos_s1;

	// The parser only consumes a byte that is actually held.
	a_take_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> valid_s1) else $error("parser took from an empty input register");

endmodule

@@ rtl/rwhp_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_parser: header walker and summary builder
// Updates the parse state for one byte per cycle while no final byte waits,
// and forms the summary on the final byte of a file.
// ----------------------------------------------------------------------------
module rwhp_parser #(
	parameter int unsigned POSITION_BITS = rwhp_pkg::POSITION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rwhp_pkg::rwhp_item_t   item,
	input  logic                   out_free,
	output logic                   take,
	output logic                   res_valid,
	output rwhp_pkg::rwhp_result_t res
);

	localparam int unsigned NBUF = rwhp_pkg::FMT_BUF_BYTES;
	localparam logic [63:0] OFF_MAX = 64'((65'd1 << rwhp_pkg::OFFSET_BITS) - 65'd1);

	rwhp_pkg::rwhp_phase_t phase_q, phase_n;
	logic [5:0]                 cnt_q, cnt_n;
	logic [32:0]                skip_q, skip_n;
	logic [POSITION_BITS-1:0]   pos_q, pos_n;
	logic [31:0]                name_q, name_n;
	logic [31:0]                len_q, len_n;
	logic                       fail_q, fail_n;
	rwhp_pkg::rwhp_kind_t  kind_q, kind_n;
	logic [15:0]                ch_q, ch_n;
	logic [31:0]                rate_q, rate_n;
	logic [31:0]                brate_q, brate_n;
	logic [15:0]                align_q, align_n;
	logic [15:0]                bits_q, bits_n;
	logic [15:0]                vbits_q, vbits_n;
	logic [31:0]                mask_q, mask_n;
	logic [rwhp_pkg::OFFSET_BITS-1:0] doff_q, doff_n;
	logic [31:0]                dsize_q, dsize_n;

	logic [7:0]  fbuf_q [NBUF];
	logic [7:0]  fb     [NBUF];
	logic        buf_clear;
	logic        buf_write;

	logic [31:0] shift_name;
	logic [5:0]  cnt_inc;
	logic [15:0] tag;
	logic [63:0] pos_wide;
	logic        eos_take;
	rwhp_pkg::rwhp_status_t status;

	assign take     = item.valid && (!item.eos || out_free);
	assign eos_take = take && item.eos;

	always_comb begin
		phase_n   = phase_q;
		cnt_n     = cnt_q;
		skip_n    = skip_q;
		name_n    = name_q;
		len_n     = len_q;
		fail_n    = fail_q;
		kind_n    = kind_q;
		ch_n      = ch_q;
		rate_n    = rate_q;
		brate_n   = brate_q;
		align_n   = align_q;
		bits_n    = bits_q;
		vbits_n   = vbits_q;
		mask_n    = mask_q;
		doff_n    = doff_q;
		dsize_n   = dsize_q;
		buf_clear = 1'b0;
		buf_write = 1'b0;

		pos_n      = (pos_q != '1) ? pos_q + 1'b1 : pos_q;
		pos_wide   = 64'(pos_n);
		shift_name = {rwhp_pkg::upcase(item.data_byte), name_q[31:8]};
		cnt_inc    = cnt_q + 6'd1;

		// Buffer as it stands after this byte, for a parse on the last fmt byte.
		for (int i = 0; i < NBUF; i++) begin
			fb[i] = (phase_q == rwhp_pkg::PH_FMT && cnt_q == 6'(i)) ? item.data_byte
				: fbuf_q[i];
		end
		tag = {fb[1], fb[0]};

		unique case (phase_q)
			rwhp_pkg::PH_HEADER: begin
				name_n = shift_name;
				if (cnt_q == 6'd3 && shift_name != rwhp_pkg::NAME_RIFF) begin
					fail_n = 1'b1;
				end
				if (cnt_q == 6'd11) begin
					if (shift_name != rwhp_pkg::NAME_WAVE) begin
						fail_n = 1'b1;
					end
					phase_n = fail_n ? rwhp_pkg::PH_FAILED : rwhp_pkg::PH_CHUNK;
					cnt_n   = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			rwhp_pkg::PH_CHUNK: begin
				if (cnt_q < 6'd4) begin
					name_n = shift_name;
				end else begin
					len_n = {item.data_byte, len_q[31:8]};
				end
				if (cnt_q == 6'd7) begin
					cnt_n = '0;
					if (name_n == rwhp_pkg::NAME_FMT && len_n <= 32'(rwhp_pkg::FMT_MAX_BYTES)) begin
						// An empty fmt body reads as all zero, which changes nothing.
						buf_clear = 1'b1;
						phase_n   = (len_n == '0) ? rwhp_pkg::PH_CHUNK : rwhp_pkg::PH_FMT;
					end else begin
						if (name_n == rwhp_pkg::NAME_DATA) begin
							doff_n  = (pos_wide > OFF_MAX) ? '1
								: pos_wide[rwhp_pkg::OFFSET_BITS-1:0];
							dsize_n = len_n;
						end
						skip_n  = {1'b0, len_n} + 33'(len_n[0]);
						phase_n = (skip_n == '0) ? rwhp_pkg::PH_CHUNK : rwhp_pkg::PH_SKIP;
					end
				end else begin
					cnt_n = cnt_inc;
				end
			end
			rwhp_pkg::PH_FMT: begin
				buf_write = 1'b1;
				cnt_n     = cnt_inc;
				if (32'(cnt_inc) >= len_q) begin
					if (tag == rwhp_pkg::TAG_PCM || tag == rwhp_pkg::TAG_EXT) begin
						ch_n    = {fb[3], fb[2]};
						rate_n  = {fb[7], fb[6], fb[5], fb[4]};
						brate_n = {fb[11], fb[10], fb[9], fb[8]};
						align_n = {fb[13], fb[12]};
						bits_n  = {fb[15], fb[14]};
					end
					if (tag == rwhp_pkg::TAG_PCM) begin
						kind_n = rwhp_pkg::KIND_PCM;
					end else if (tag == rwhp_pkg::TAG_EXT) begin
						kind_n  = rwhp_pkg::KIND_EXT;
						vbits_n = {fb[19], fb[18]};
						mask_n  = {fb[23], fb[22], fb[21], fb[20]};
					end
					cnt_n   = '0;
					skip_n  = 33'(len_q[0]);
					phase_n = len_q[0] ? rwhp_pkg::PH_SKIP : rwhp_pkg::PH_CHUNK;
				end
			end
			rwhp_pkg::PH_SKIP: begin
				if (skip_q != '0) begin
					skip_n = skip_q - 33'd1;
				end
				if (skip_n == '0) begin
					phase_n = rwhp_pkg::PH_CHUNK;
				end
			end
			default: begin
			end
		endcase

		if (fail_n || phase_n == rwhp_pkg::PH_HEADER) begin
			status = rwhp_pkg::ST_BAD_HEADER;
		end else if (phase_n == rwhp_pkg::PH_FMT) begin
			status = rwhp_pkg::ST_TRUNC_FMT;
		end else if (dsize_n != '0 && doff_n != '0
			&& (kind_n == rwhp_pkg::KIND_PCM || kind_n == rwhp_pkg::KIND_EXT)) begin
			status = rwhp_pkg::ST_OK;
		end else begin
			status = rwhp_pkg::ST_NO_FORMAT;
		end

		res = '0;
		res.status = status;
		if (status == rwhp_pkg::ST_OK || status == rwhp_pkg::ST_NO_FORMAT) begin
			res.format_kind   = kind_n;
			res.channel_count = ch_n;
			res.sample_rate   = rate_n;
			res.byte_rate     = brate_n;
			res.block_align   = align_n;
			res.sample_bits   = bits_n;
			if (kind_n == rwhp_pkg::KIND_EXT) begin
				res.valid_bits   = vbits_n;
				res.speaker_mask = mask_n;
			end
			res.data_offset = doff_n;
			res.data_size   = dsize_n;
		end
	end

	assign res_valid = eos_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rwhp_pkg::PH_HEADER;
			cnt_q   <= '0;
			skip_q  <= '0;
			pos_q   <= '0;
			name_q  <= '0;
			len_q   <= '0;
			fail_q  <= 1'b0;
			kind_q  <= rwhp_pkg::KIND_UNKNOWN;
			ch_q    <= '0;
			rate_q  <= '0;
			brate_q <= '0;
			align_q <= '0;
			bits_q  <= '0;
			vbits_q <= '0;
			mask_q  <= '0;
			doff_q  <= '0;
			dsize_q <= '0;
		end else if (eos_take) begin
			// The summary is out; the next byte starts a new file.
			phase_q <= rwhp_pkg::PH_HEADER;
			cnt_q   <= '0;
			skip_q  <= '0;
			pos_q   <= '0;
			name_q  <= '0;
			len_q   <= '0;
			fail_q  <= 1'b0;
			kind_q  <= rwhp_pkg::KIND_UNKNOWN;
			ch_q    <= '0;
			rate_q  <= '0;
			brate_q <= '0;
			align_q <= '0;
			bits_q  <= '0;
			vbits_q <= '0;
			mask_q  <= '0;
			doff_q  <= '0;
			dsize_q <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			skip_q  <= skip_n;
			pos_q   <= pos_n;
			name_q  <= name_n;
			len_q   <= len_n;
			fail_q  <= fail_n;
			kind_q  <= kind_n;
			ch_q    <= ch_n;
			rate_q  <= rate_n;
			brate_q <= brate_n;
			align_q <= align_n;
			bits_q  <= bits_n;
			vbits_q <= vbits_n;
			mask_q  <= mask_n;
			doff_q  <= doff_n;
			dsize_q <= dsize_n;
		end
	end

	// The fmt buffer is cleared at the start of every captured fmt body, so
	// it needs no reset.
	always_ff @(posedge clk) begin
		if (take && !item.eos) begin
			for (int i = 0; i < NBUF; i++) begin
				if (buf_clear) begin
					fbuf_q[i] <= '0;
				end else if (buf_write && cnt_q == 6'(i)) begin
					fbuf_q[i] <= item.data_byte;
				end
			end
		end
	end

	a_failed_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rwhp_pkg::PH_FAILED |-> fail_q)
		else $error("failed phase without a failure code");

	a_fmt_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rwhp_pkg::PH_FMT |-> len_q != '0
			&& len_q <= 32'(rwhp_pkg::FMT_MAX_BYTES))
		else $error("fmt capture with an out-of-range length");

	a_restart_after_eos: assert property (@(posedge clk) disable iff (!arst_n)
		eos_take |=> phase_q == rwhp_pkg::PH_HEADER && pos_q == '0)
		else $error("parser did not restart after the final byte");

	a_pos_counts: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item.eos && pos_q != '1 |=> pos_q == $past(pos_q) + 1'b1)
		else $error("stream position did not advance");

endmodule

@@ rtl/rwhp_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwhp_out_stage: summary register
// Holds one summary until the downstream side takes it.
// ----------------------------------------------------------------------------
module rwhp_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  rwhp_pkg::rwhp_result_t res,
	output logic                   out_free,
	rwhp_out_if.source             summary
);

	logic                   valid_q;
	rwhp_pkg::rwhp_result_t res_q;

	assign out_free = !valid_q || summary.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (summary.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign summary.valid         = valid_q;
	assign summary.status        = res_q.status;
	assign summary.format_kind   = res_q.format_kind;
	assign summary.channel_count = res_q.channel_count;
	assign summary.sample_rate   = res_q.sample_rate;
	assign summary.byte_rate     = res_q.byte_rate;
	assign summary.block_align   = res_q.block_align;
	assign summary.sample_bits   = res_q.sample_bits;
	assign summary.valid_bits    = res_q.valid_bits;
	assign summary.speaker_mask  = res_q.speaker_mask;
	assign summary.data_offset   = res_q.data_offset;
	assign summary.data_size     = res_q.data_size;

	// A new summary never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || summary.ready)
		else $error("summary overwritten before it was taken");

endmodule
